### hdl/odenc_pkg.sv
// Shared types and constants for the octahedral direction encoder.
// No dependencies; used by the interfaces, the divide stage and the top level.
`default_nettype none

package odenc_pkg;

    // Input component width (two's complement)
    localparam int COMPONENT_BITS = 16;

    // Magnitude of a component: holds 2^(COMPONENT_BITS-1) exactly
    localparam int MAG_W = COMPONENT_BITS;
    // L1 norm and the divider's partial remainder
    localparam int L1_W = COMPONENT_BITS + 2;

    // Output coordinate width, signed Q1.15
    localparam int OUT_W = 16;
    // Quotient magnitude 0..2^(OUT_W-1)
    localparam int Q_W = OUT_W;
    // Folded magnitude, one bit more so that 1.0 minus a quotient fits
    localparam int QM_W = Q_W + 1;

    // Divider split: quotient bits resolved in each pipeline stage
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = Q_W / BITS_PER_STAGE;

    // Divider state that travels down the pipeline
    typedef struct packed {
        logic [L1_W-1:0] l1;
        logic [L1_W-1:0] rem_x;
        logic [L1_W-1:0] rem_y;
        logic [Q_W-1:0]  q_x;
        logic [Q_W-1:0]  q_y;
        logic            bit_x;   // dividend bit still to shift in
        logic            bit_y;
        logic            neg_x;
        logic            neg_y;
        logic            neg_z;
        logic            zero;
    } div_t;

endpackage

`default_nettype wire

### hdl/odenc_if.sv
// Valid/ready channels of the octahedral direction encoder.
// Depends on odenc_pkg for the component and output widths.
`default_nettype none

interface odenc_dir_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [odenc_pkg::COMPONENT_BITS-1:0] dir_x;
    logic signed [odenc_pkg::COMPONENT_BITS-1:0] dir_y;
    logic signed [odenc_pkg::COMPONENT_BITS-1:0] dir_z;

    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface odenc_oct_if;
    logic                               valid;
    logic                               ready;
    logic signed [odenc_pkg::OUT_W-1:0] oct_u;
    logic signed [odenc_pkg::OUT_W-1:0] oct_v;
    logic                               zero_vector;

    modport source (output valid, oct_u, oct_v, zero_vector, input ready);
    modport sink   (input valid, oct_u, oct_v, zero_vector, output ready);
endinterface

`default_nettype wire

### hdl/odenc_div_stage.sv
// One registered stage of the restoring divider: resolves a few quotient
// bits of both x and y quotients. Depends on odenc_pkg.
`default_nettype none

module odenc_div_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire odenc_pkg::div_t  up,
    input  wire logic             up_valid,
    output logic                  up_ready,
    output odenc_pkg::div_t       dn,
    output logic                  dn_valid,
    input  wire logic             dn_ready
);

    odenc_pkg::div_t work;
    odenc_pkg::div_t data_reg;
    logic            valid_reg;

    // Shift-compare-subtract steps, one quotient bit each
    always_comb
    begin : div_steps
        logic [odenc_pkg::L1_W-1:0] trial_x;
        logic [odenc_pkg::L1_W-1:0] trial_y;
        work = up;
        for (int i = 0; i < odenc_pkg::BITS_PER_STAGE; i++)
        begin
            trial_x = {work.rem_x[odenc_pkg::L1_W-2:0], work.bit_x};
            trial_y = {work.rem_y[odenc_pkg::L1_W-2:0], work.bit_y};
            if (trial_x >= work.l1)
            begin
                work.rem_x = trial_x - work.l1;
                work.q_x   = {work.q_x[odenc_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                work.rem_x = trial_x;
                work.q_x   = {work.q_x[odenc_pkg::Q_W-2:0], 1'b0};
            end
            if (trial_y >= work.l1)
            begin
                work.rem_y = trial_y - work.l1;
                work.q_y   = {work.q_y[odenc_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                work.rem_y = trial_y;
                work.q_y   = {work.q_y[odenc_pkg::Q_W-2:0], 1'b0};
            end
            // only the first step brings in a nonzero dividend bit
            work.bit_x = 1'b0;
            work.bit_y = 1'b0;
        end
    end

    // Stage advances when empty or when the next stage takes its item
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= work;
        end
    end

    assign dn       = data_reg;
    assign dn_valid = valid_reg;

endmodule

`default_nettype wire

### hdl/octahedral_direction_encode_core.sv
// Octahedral direction encoder top level: magnitude/L1 stage, pipelined
// divider stages and fold/saturate output stage. Depends on odenc_pkg,
// odenc_if and odenc_div_stage.
//
//  channel | modport | payload                        | transfer
//  --------+---------+--------------------------------+------------------
//  dir     | sink    | dir_x, dir_y, dir_z (signed)   | valid && ready
//  oct     | source  | oct_u, oct_v (Q1.15), zero_vec | valid && ready
//
// An item passes from input transfer to output valid through six
// register stages: one for magnitudes and the L1 norm (loaded at the input
// transfer), four divider stages of four quotient bits each, and one
// fold/saturate stage that is also the output register.
// One item per cycle is sustained while oct.ready is high; the ready chain stalls only full stages.
// rst_n clears all valid bits asynchronously; payload registers keep data.
`default_nettype none

module octahedral_direction_encode_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    odenc_dir_if.sink      dir,
    odenc_oct_if.source    oct
);

    localparam logic [odenc_pkg::QM_W-1:0] Q_ONE = {1'b1, {(odenc_pkg::QM_W-1){1'b0}}} >> 1;
    localparam logic [odenc_pkg::OUT_W-1:0] Q_MAX = {1'b0, {(odenc_pkg::OUT_W-1){1'b1}}};

    // Give a magnitude a sign; positive 1.0 saturates to the largest code
    function automatic logic [odenc_pkg::OUT_W-1:0] signed_q15(
        input logic [odenc_pkg::QM_W-1:0] m,
        input logic                       neg
    );
        logic [odenc_pkg::QM_W-1:0] n;
        n = '0 - m;
        if (neg)
            return n[odenc_pkg::OUT_W-1:0];
        else if (m > {1'b0, Q_MAX})
            return Q_MAX;
        else
            return m[odenc_pkg::OUT_W-1:0];
    endfunction

    odenc_pkg::div_t                   stg       [odenc_pkg::DIV_STAGES+1];
    logic [odenc_pkg::DIV_STAGES:0]    stg_valid;
    logic [odenc_pkg::DIV_STAGES:0]    stg_ready;

    odenc_pkg::div_t                   s0_next;
    odenc_pkg::div_t                   s0_reg;
    logic                              s0_valid_reg;

    logic [odenc_pkg::MAG_W-1:0]       mag_x;
    logic [odenc_pkg::MAG_W-1:0]       mag_y;
    logic [odenc_pkg::MAG_W-1:0]       mag_z;

    logic [odenc_pkg::QM_W-1:0]        m_u;
    logic [odenc_pkg::QM_W-1:0]        m_v;
    logic [odenc_pkg::OUT_W-1:0]       u_next;
    logic [odenc_pkg::OUT_W-1:0]       v_next;
    logic [odenc_pkg::OUT_W-1:0]       u_reg;
    logic [odenc_pkg::OUT_W-1:0]       v_reg;
    logic                              zero_reg;
    logic                              out_valid_reg;

    // Stage 0: magnitudes, signs, L1 norm, divider seed
    always_comb
    begin
        mag_x = dir.dir_x[odenc_pkg::COMPONENT_BITS-1] ? (~dir.dir_x + 1'b1) : dir.dir_x;
        mag_y = dir.dir_y[odenc_pkg::COMPONENT_BITS-1] ? (~dir.dir_y + 1'b1) : dir.dir_y;
        mag_z = dir.dir_z[odenc_pkg::COMPONENT_BITS-1] ? (~dir.dir_z + 1'b1) : dir.dir_z;
        s0_next.l1    = odenc_pkg::L1_W'(mag_x) + odenc_pkg::L1_W'(mag_y)
                      + odenc_pkg::L1_W'(mag_z);
        // dividend is mag << 15; its upper bits seed the remainder
        s0_next.rem_x = odenc_pkg::L1_W'(mag_x[odenc_pkg::MAG_W-1:1]);
        s0_next.rem_y = odenc_pkg::L1_W'(mag_y[odenc_pkg::MAG_W-1:1]);
        s0_next.bit_x = mag_x[0];
        s0_next.bit_y = mag_y[0];
        s0_next.q_x   = '0;
        s0_next.q_y   = '0;
        s0_next.neg_x = dir.dir_x[odenc_pkg::COMPONENT_BITS-1];
        s0_next.neg_y = dir.dir_y[odenc_pkg::COMPONENT_BITS-1];
        s0_next.neg_z = dir.dir_z[odenc_pkg::COMPONENT_BITS-1];
        s0_next.zero  = (dir.dir_x == '0) && (dir.dir_y == '0) && (dir.dir_z == '0);
    end

    assign dir.ready = !s0_valid_reg || stg_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (dir.ready)
        begin
            s0_valid_reg <= dir.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir.valid && dir.ready)
        begin
            s0_reg <= s0_next;
        end
    end

    assign stg[0]       = s0_reg;
    assign stg_valid[0] = s0_valid_reg;

    // Divider stages
    for (genvar k = 0; k < odenc_pkg::DIV_STAGES; k++)
    begin : g_div
        odenc_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up       (stg[k]),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .dn       (stg[k+1]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1])
        );
    end

    // Output stage: hemisphere fold, sign, saturate
    always_comb
    begin
        if (stg[odenc_pkg::DIV_STAGES].neg_z)
        begin
            m_u = Q_ONE - {1'b0, stg[odenc_pkg::DIV_STAGES].q_y};
            m_v = Q_ONE - {1'b0, stg[odenc_pkg::DIV_STAGES].q_x};
        end
        else
        begin
            m_u = {1'b0, stg[odenc_pkg::DIV_STAGES].q_x};
            m_v = {1'b0, stg[odenc_pkg::DIV_STAGES].q_y};
        end
        if (stg[odenc_pkg::DIV_STAGES].zero)
        begin
            u_next = '0;
            v_next = '0;
        end
        else
        begin
            u_next = signed_q15(m_u, stg[odenc_pkg::DIV_STAGES].neg_x);
            v_next = signed_q15(m_v, stg[odenc_pkg::DIV_STAGES].neg_y);
        end
    end

    assign stg_ready[odenc_pkg::DIV_STAGES] = !out_valid_reg || oct.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_ready[odenc_pkg::DIV_STAGES])
        begin
            out_valid_reg <= stg_valid[odenc_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_valid[odenc_pkg::DIV_STAGES] && stg_ready[odenc_pkg::DIV_STAGES])
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            zero_reg <= stg[odenc_pkg::DIV_STAGES].zero;
        end
    end

    assign oct.valid       = out_valid_reg;
    assign oct.oct_u       = u_reg;
    assign oct.oct_v       = v_reg;
    assign oct.zero_vector = zero_reg;

    // Checks
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        oct.valid && oct.zero_vector |-> (oct.oct_u == '0) && (oct.oct_v == '0))
        else $error("zero vector result carries nonzero coordinates");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !dir.ready |-> (&stg_valid) && out_valid_reg)
        else $error("input stalled while the pipeline has a bubble");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[odenc_pkg::DIV_STAGES] && !stg[odenc_pkg::DIV_STAGES].zero
        |-> ({1'b0, stg[odenc_pkg::DIV_STAGES].q_x} <= Q_ONE)
            && ({1'b0, stg[odenc_pkg::DIV_STAGES].q_y} <= Q_ONE))
        else $error("quotient above 1.0");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[odenc_pkg::DIV_STAGES] && stg_ready[odenc_pkg::DIV_STAGES]
        |=> out_valid_reg)
        else $error("last divider stage handed off an item that was lost");

endmodule

`default_nettype wire
